@@ rtl/gbe_pkg.sv @@
// Shared types, request codes and step offsets for the grid escape block.
`timescale 1ns / 1ps
package gbe_pkg;

    // Request codes carried by the func field.
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_SOLVE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_EV_RD,
        ST_EV_WR,
        ST_VCLR,
        ST_ORG_RD,
        ST_ORG_CHK,
        ST_POP,
        ST_POP_W,
        ST_NB_RD,
        ST_NB_CHK,
        ST_DONE
    } t_state;

    // Step 0 is the center cell, steps 1 to 4 are the four neighbors.
    function automatic logic [1:0] off_dx(input logic [2:0] k);
        logic [1:0] d;
        begin
            unique case (k)
                3'd1:    d = 2'b11;
                3'd3:    d = 2'b01;
                default: d = 2'b00;
            endcase
            return d;
        end
    endfunction

    function automatic logic [1:0] off_dy(input logic [2:0] k);
        logic [1:0] d;
        begin
            unique case (k)
                3'd2:    d = 2'b01;
                3'd4:    d = 2'b11;
                default: d = 2'b00;
            endcase
            return d;
        end
    endfunction

endpackage

@@ rtl/gbe_ram.sv @@
// Single write port, single read port memory with registered read data.
`timescale 1ns / 1ps
module gbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/grid_bfs_escape_with_deadlines.sv @@
// Grid escape search: blocking-time grid, visited map and frontier queue in memories.
// A blocking event visits the center cell and its four neighbors: a read step and a
// write step per in-grid cell, and a read step alone per off-grid neighbor. A solve
// sweeps the visited map, reads and checks the origin, then pops each dequeued cell,
// waits for its queue data, and probes each neighbor with a read step and, if in grid,
// a check step; the single grid read port sets this pace. A clear request, and the pass
// after reset, each write every grid cell, during which no item is accepted. Reset is synchronous and active low.
`timescale 1ns / 1ps
module grid_bfs_escape_with_deadlines
    import gbe_pkg::*;
#(
    parameter int GRID_SIZE = 512,
    parameter int TIME_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [8:0]  i_cell_x,
    input  logic [8:0]  i_cell_y,
    input  logic [9:0]  i_block_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reachable,
    output logic [10:0] o_arrival_time
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int TW    = TIME_BITS + 1;
    localparam int QW    = 2 * CW + TW;

    localparam logic [TW-1:0] NEVER    = {1'b1, {TIME_BITS{1'b0}}};
    localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);

    t_state r_state, n_state;
    logic [2:0]    r_k, n_k;
    logic [CW-1:0] r_x, n_x, r_y, n_y, r_nx, n_nx, r_ny, n_ny;
    logic [TW-1:0] r_t, n_t;
    logic [AW-1:0] r_addr, n_addr, r_nidx, n_nidx;
    logic [AW:0]   r_head, n_head, r_tail, n_tail;
    logic          r_res_reach, n_res_reach;
    logic [TW-1:0] r_res_arr, n_res_arr;
    logic          r_out_valid, r_reach;
    logic [10:0]   r_arr;

    logic          g_we, v_we, q_we;
    logic [AW-1:0] g_waddr, g_raddr, v_waddr, v_raddr, q_waddr, q_raddr;
    logic [TW-1:0] g_wdata, g_rdata;
    logic          v_wdata, v_rdata;
    logic [QW-1:0] q_wdata, q_rdata;

    logic          w_acc, w_ev_ok, w_in_grid, w_can_load;
    logic [31:0]   w_cx32, w_cy32, w_t32, w_lin, w_arr32;
    logic [1:0]    w_dx, w_dy;
    logic [CW:0]   w_nx, w_ny;
    logic [TW-1:0] w_qt;

    // Memories: blocking times, visited marks, frontier queue.
    gbe_ram #(.WIDTH(TW), .DEPTH(CELLS)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata)
    );
    gbe_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    gbe_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    // Input decode and neighbor address arithmetic.
    always_comb begin
        w_cx32    = {23'b0, i_cell_x};
        w_cy32    = {23'b0, i_cell_y};
        w_t32     = {22'b0, i_block_time};
        w_ev_ok   = (w_cx32 < 32'(GRID_SIZE)) && (w_cy32 < 32'(GRID_SIZE));
        w_acc     = i_in_valid && (r_state == ST_IDLE);
        w_dx      = off_dx(r_k);
        w_dy      = off_dy(r_k);
        w_nx      = {1'b0, r_x} + {{(CW-1){w_dx[1]}}, w_dx};
        w_ny      = {1'b0, r_y} + {{(CW-1){w_dy[1]}}, w_dy};
        w_in_grid = (w_nx < (CW+1)'(GRID_SIZE)) && (w_ny < (CW+1)'(GRID_SIZE));
        w_lin     = 32'(w_ny[CW-1:0]) * 32'(GRID_SIZE) + 32'(w_nx[CW-1:0]);
        w_qt      = q_rdata[TW-1:0] + TW'(1);
        w_can_load = !r_out_valid || !i_out_stall;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (r_addr == LAST_IDX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (i_func)
                        FUNC_ADD:   n_state = w_ev_ok ? ST_EV_RD : ST_IDLE;
                        FUNC_SOLVE: n_state = ST_VCLR;
                        FUNC_CLEAR: n_state = ST_CLR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EV_RD: begin
                if (w_in_grid) n_state = ST_EV_WR;
                else if (r_k == 3'd4) n_state = ST_IDLE;
            end
            ST_EV_WR: begin
                n_state = (r_k == 3'd4) ? ST_IDLE : ST_EV_RD;
            end
            ST_VCLR: begin
                if (r_addr == LAST_IDX) n_state = ST_ORG_RD;
            end
            ST_ORG_RD: n_state = ST_ORG_CHK;
            ST_ORG_CHK: begin
                if (g_rdata[TIME_BITS] || g_rdata == '0) n_state = ST_DONE;
                else n_state = ST_POP;
            end
            ST_POP: begin
                n_state = (r_head == r_tail) ? ST_DONE : ST_POP_W;
            end
            ST_POP_W: n_state = ST_NB_RD;
            ST_NB_RD: begin
                if (w_in_grid) n_state = ST_NB_CHK;
                else if (r_k == 3'd4) n_state = ST_POP;
            end
            ST_NB_CHK: begin
                if (!v_rdata && g_rdata[TIME_BITS]) n_state = ST_DONE;
                else n_state = (r_k == 3'd4) ? ST_POP : ST_NB_RD;
            end
            ST_DONE: begin
                if (w_can_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath controls and memory ports.
    always_comb begin
        n_k = r_k;   n_x = r_x;   n_y = r_y;   n_nx = r_nx;  n_ny = r_ny;
        n_t = r_t;   n_addr = r_addr;  n_nidx = r_nidx;
        n_head = r_head;  n_tail = r_tail;
        n_res_reach = r_res_reach;  n_res_arr = r_res_arr;
        g_we = 1'b0;  g_waddr = r_nidx;  g_wdata = r_t;  g_raddr = w_lin[AW-1:0];
        v_we = 1'b0;  v_waddr = r_nidx;  v_wdata = 1'b1; v_raddr = w_lin[AW-1:0];
        q_we = 1'b0;  q_waddr = r_tail[AW-1:0];  q_wdata = {r_nx, r_ny, r_t};
        q_raddr = r_head[AW-1:0];
        unique case (r_state)
            ST_CLR: begin
                g_we    = 1'b1;
                g_waddr = r_addr;
                g_wdata = NEVER;
                n_addr  = (r_addr == LAST_IDX) ? '0 : r_addr + AW'(1);
            end
            ST_IDLE: begin
                if (w_acc) begin
                    n_x    = w_cx32[CW-1:0];
                    n_y    = w_cy32[CW-1:0];
                    n_t    = {1'b0, w_t32[TIME_BITS-1:0]};
                    n_k    = 3'd0;
                    n_addr = '0;
                end
            end
            ST_EV_RD: begin
                n_nidx = w_lin[AW-1:0];
                if (!w_in_grid) n_k = r_k + 3'd1;
            end
            ST_EV_WR: begin
                if (r_t < g_rdata) g_we = 1'b1;
                n_k = r_k + 3'd1;
            end
            ST_VCLR: begin
                v_we    = 1'b1;
                v_waddr = r_addr;
                v_wdata = 1'b0;
                n_addr  = (r_addr == LAST_IDX) ? '0 : r_addr + AW'(1);
            end
            ST_ORG_RD: begin
                g_raddr = '0;
            end
            ST_ORG_CHK: begin
                n_res_arr = '0;
                if (g_rdata[TIME_BITS]) begin
                    n_res_reach = 1'b1;
                end else if (g_rdata == '0) begin
                    n_res_reach = 1'b0;
                end else begin
                    v_we    = 1'b1;
                    v_waddr = '0;
                    q_we    = 1'b1;
                    q_waddr = '0;
                    q_wdata = '0;
                    n_head  = '0;
                    n_tail  = (AW+1)'(1);
                end
            end
            ST_POP: begin
                if (r_head == r_tail) begin
                    n_res_reach = 1'b0;
                    n_res_arr   = '0;
                end else begin
                    n_head = r_head + (AW+1)'(1);
                end
            end
            ST_POP_W: begin
                n_x = q_rdata[QW-1 -: CW];
                n_y = q_rdata[QW-CW-1 -: CW];
                n_t = w_qt;
                n_k = 3'd1;
            end
            ST_NB_RD: begin
                n_nidx = w_lin[AW-1:0];
                n_nx   = w_nx[CW-1:0];
                n_ny   = w_ny[CW-1:0];
                if (!w_in_grid) n_k = r_k + 3'd1;
            end
            ST_NB_CHK: begin
                n_k = r_k + 3'd1;
                if (!v_rdata) begin
                    if (g_rdata[TIME_BITS]) begin
                        n_res_reach = 1'b1;
                        n_res_arr   = r_t;
                    end else if (g_rdata > r_t) begin
                        v_we = 1'b1;
                        if (r_tail < (AW+1)'(CELLS)) begin
                            q_we   = 1'b1;
                            n_tail = r_tail + (AW+1)'(1);
                        end
                    end
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
        r_k <= n_k;   r_x <= n_x;   r_y <= n_y;   r_nx <= n_nx;  r_ny <= n_ny;
        r_t <= n_t;   r_nidx <= n_nidx;  r_head <= n_head;  r_tail <= n_tail;
        r_res_reach <= n_res_reach;  r_res_arr <= n_res_arr;
    end

    // Output register: a finished result waits here while new items come in.
    assign w_arr32 = 32'(r_res_arr);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_can_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == ST_DONE && w_can_load) begin
            r_reach <= r_res_reach;
            r_arr   <= r_res_reach ? w_arr32[10:0] : 11'd0;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_reachable    = r_reach;
    assign o_arrival_time = r_arr;

endmodule
